// ----- design/csteer_pkg.sv -----
// shared types, constants and helpers of the cascaded pid steering unit
// no dependencies; imported by every module of the block
package csteer_pkg;

  // field and datapath widths
  localparam int GAIN_W    = 16;
  localparam int CLR_W     = 15;
  localparam int DATA_W    = 16;
  localparam int ERR_W     = 17;
  localparam int SUM_W     = 21;
  localparam int OPND_W    = 21;
  localparam int PROD_W    = 30;
  localparam int ACC_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FRAC_W    = 8;

  // default limits
  localparam int DEF_RATE_SETPOINT_MAX = 4096;
  localparam int DEF_DRIVE_OUT_MAX     = 1024;
  localparam int DEF_HEADING_SUM_LIMIT = 8192;
  localparam int DEF_RATE_SUM_LIMIT    = 8192;
  localparam int DEF_RATE_OUT_MAX      = 1024;

  // operating modes
  localparam logic [MODE_W-1:0] MODE_STOP   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DRIVE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROTATE = 2'd2;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DRIVE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ROTATE = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_GAIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLEARANCE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN_I = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_GAIN_D = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_P    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_I    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN_D    = 3'd7;

  // accumulator operations
  localparam logic [1:0] ACC_HOLD = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;

  localparam logic signed [ERR_W-1:0] STOP_BAND = 17'sd2;

  typedef struct packed {
    logic [GAIN_W-1:0] drive_gain;
    logic [CLR_W-1:0]  clearance;
    logic [GAIN_W-1:0] heading_gain_p;
    logic [GAIN_W-1:0] heading_gain_i;
    logic [GAIN_W-1:0] heading_gain_d;
    logic [GAIN_W-1:0] rate_gain_p;
    logic [GAIN_W-1:0] rate_gain_i;
    logic [GAIN_W-1:0] rate_gain_d;
  } gains_t;

  typedef struct packed {
    logic       prod_en;
    logic [1:0] acc_op;
  } mul_ctl_t;

  // symmetric saturation
  function automatic logic signed [ACC_W-1:0] sat(input logic signed [ACC_W-1:0] v,
                                                  input logic signed [ACC_W-1:0] lim);
    if (v > lim) begin
      sat = lim;
    end else if (v < -lim) begin
      sat = -lim;
    end else begin
      sat = v;
    end
  endfunction

  // error magnitude under the stop band
  function automatic logic in_band(input logic signed [ERR_W-1:0] e);
    in_band = (e < STOP_BAND) && (e > -STOP_BAND);
  endfunction

endpackage

// ----- design/csteer_cmd_if.sv -----
// command and sensor channel of the steering unit
// depends on csteer_pkg for field widths
interface csteer_cmd_if;
  import csteer_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] odometer;
  logic [CLR_W-1:0]         obstacle_distance;
  logic signed [DATA_W-1:0] heading;
  logic signed [DATA_W-1:0] turn_rate;

  modport source(output valid, func, target, odometer, obstacle_distance, heading,
                 turn_rate, input ready);
  modport sink(input valid, func, target, odometer, obstacle_distance, heading,
               turn_rate, output ready);
endinterface

// ----- design/csteer_motor_if.sv -----
// motor command channel of the steering unit
// depends on csteer_pkg for field widths
interface csteer_motor_if;
  import csteer_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] left_drive;
  logic signed [DATA_W-1:0] right_drive;
  logic [MODE_W-1:0]        mode_now;
  logic                     finished;

  modport source(output valid, left_drive, right_drive, mode_now, finished, input ready);
  modport sink(input valid, left_drive, right_drive, mode_now, finished, output ready);
endinterface

// ----- design/csteer_cfg.sv -----
// configuration register bank: gains and obstacle clearance
// depends on csteer_pkg
module csteer_cfg
  import csteer_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data,
  output gains_t               gains
);

  // write decode, reset to the documented defaults
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.drive_gain     <= 16'd256;
      gains.clearance      <= 15'd20;
      gains.heading_gain_p <= 16'd256;
      gains.heading_gain_i <= '0;
      gains.heading_gain_d <= '0;
      gains.rate_gain_p    <= 16'd256;
      gains.rate_gain_i    <= '0;
      gains.rate_gain_d    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DRIVE_GAIN:     gains.drive_gain     <= cfg_data;
        REG_CLEARANCE:      gains.clearance      <= cfg_data[CLR_W-1:0];
        REG_HEADING_GAIN_P: gains.heading_gain_p <= cfg_data;
        REG_HEADING_GAIN_I: gains.heading_gain_i <= cfg_data;
        REG_HEADING_GAIN_D: gains.heading_gain_d <= cfg_data;
        REG_RATE_GAIN_P:    gains.rate_gain_p    <= cfg_data;
        REG_RATE_GAIN_I:    gains.rate_gain_i    <= cfg_data;
        REG_RATE_GAIN_D:    gains.rate_gain_d    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/csteer_mul.sv -----
// shared q8.8 multiply unit with floor shift and accumulator
// depends on csteer_pkg
module csteer_mul
  import csteer_pkg::*;
(
  input  logic                     clk,
  input  mul_ctl_t                 ctl,
  input  logic [GAIN_W-1:0]        gain,
  input  logic signed [OPND_W-1:0] opnd,
  output logic signed [ACC_W-1:0]  acc
);

  logic signed [GAIN_W+OPND_W:0] full;
  logic signed [PROD_W-1:0]      prod;

  // unsigned gain times signed operand; dropping the low bits floors
  assign full = $signed({1'b0, gain}) * opnd;

  // product register
  always_ff @(posedge clk) begin
    if (ctl.prod_en) begin
      prod <= full[GAIN_W+OPND_W:FRAC_W];
    end
  end

  // term accumulator
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      ACC_LOAD: acc <= ACC_W'(prod);
      ACC_ADD:  acc <= acc + ACC_W'(prod);
      default:  acc <= acc;
    endcase
  end

endmodule

// ----- design/cascaded_pid_steering_unit.sv -----
// Cascaded PID steering unit: one item in at a time over the cmd channel, one motor item
// out per item. Commands (start drive, start rotate, stop) and ticks in stop mode go from
// acceptance to the final state, then to the result register; drive and rotate ticks run
// the sequencer that walks every gain product through the one shared multiplier and
// accumulator, one product per cycle. A new item is taken once the result has moved into
// the output register. Gains are Q8.8 and each product is floored after the shift by 8. The
// user must write registers via cfg_we, cfg_index and cfg_data while idle; the block does not enforce it.
// depends on csteer_pkg, csteer_cmd_if, csteer_motor_if, csteer_cfg and csteer_mul
module cascaded_pid_steering_unit
  import csteer_pkg::*;
#(
  parameter int RATE_SETPOINT_MAX = DEF_RATE_SETPOINT_MAX,
  parameter int DRIVE_OUT_MAX     = DEF_DRIVE_OUT_MAX,
  parameter int HEADING_SUM_LIMIT = DEF_HEADING_SUM_LIMIT,
  parameter int RATE_SUM_LIMIT    = DEF_RATE_SUM_LIMIT,
  parameter int RATE_OUT_MAX      = DEF_RATE_OUT_MAX
) (
  input  logic                 clk,
  input  logic                 rst,
  csteer_cmd_if.sink           cmd,
  csteer_motor_if.source       motor,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [GAIN_W-1:0]    cfg_data
);

  localparam logic signed [ACC_W-1:0] SP_LIM   = ACC_W'(RATE_SETPOINT_MAX);
  localparam logic signed [ACC_W-1:0] DRV_LIM  = ACC_W'(DRIVE_OUT_MAX);
  localparam logic signed [ACC_W-1:0] HSUM_LIM = ACC_W'(HEADING_SUM_LIMIT);
  localparam logic signed [ACC_W-1:0] RSUM_LIM = ACC_W'(RATE_SUM_LIMIT);
  localparam logic signed [ACC_W-1:0] ROUT_LIM = ACC_W'(RATE_OUT_MAX);

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DERR = 4'd1;
  localparam logic [3:0] S_DMUL = 4'd2;
  localparam logic [3:0] S_DSUM = 4'd3;
  localparam logic [3:0] S_HERR = 4'd4;
  localparam logic [3:0] S_HPM  = 4'd5;
  localparam logic [3:0] S_HIM  = 4'd6;
  localparam logic [3:0] S_HDM  = 4'd7;
  localparam logic [3:0] S_HSUM = 4'd8;
  localparam logic [3:0] S_SP   = 4'd9;
  localparam logic [3:0] S_RERR = 4'd10;
  localparam logic [3:0] S_RPM  = 4'd11;
  localparam logic [3:0] S_RIM  = 4'd12;
  localparam logic [3:0] S_RDM  = 4'd13;
  localparam logic [3:0] S_RSUM = 4'd14;
  localparam logic [3:0] S_FIN  = 4'd15;

  gains_t gains;
  logic [3:0] state;
  logic [MODE_W-1:0] mode;
  logic [MODE_W-1:0] kind;
  logic signed [DATA_W-1:0] goal;
  logic signed [SUM_W-1:0] heading_integral;
  logic signed [SUM_W-1:0] rate_integral;
  logic signed [DATA_W-1:0] last_heading;
  logic signed [DATA_W-1:0] last_rate;

  // latched item fields
  logic signed [DATA_W-1:0] odo;
  logic [CLR_W-1:0] obst;
  logic signed [DATA_W-1:0] head;
  logic signed [DATA_W-1:0] rate;

  // intermediate values
  logic signed [ERR_W-1:0] err;
  logic signed [DATA_W-1:0] room;
  logic signed [ERR_W-1:0] dh;
  logic signed [ERR_W-1:0] dr;
  logic signed [DATA_W-1:0] sp;
  logic signed [ERR_W-1:0] rerr;

  // output register
  logic out_valid;
  logic signed [DATA_W-1:0] out_left;
  logic signed [DATA_W-1:0] out_right;
  logic [MODE_W-1:0] out_mode;
  logic out_done;

  mul_ctl_t mul_ctl;
  logic [GAIN_W-1:0] mul_gain;
  logic signed [OPND_W-1:0] mul_opnd;
  logic signed [ACC_W-1:0] acc;

  logic signed [OPND_W-1:0] drive_opnd;
  logic signed [ACC_W-1:0] fin_drv;
  logic [DATA_W-1:0] drv16;
  logic band;
  logic fin_go;
  logic accept;
  logic [MODE_W-1:0] mode_after;

  csteer_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .gains    (gains)
  );

  csteer_mul u_mul (
    .clk (clk),
    .ctl (mul_ctl),
    .gain(mul_gain),
    .opnd(mul_opnd),
    .acc (acc)
  );

  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign fin_go    = (state == S_FIN) && (!out_valid || motor.ready);

  // drive operand: error, or the room left before the obstacle
  always_comb begin
    if (ERR_W'(room) < err) begin
      drive_opnd = (room > 0) ? OPND_W'(room) : '0;
    end else begin
      drive_opnd = OPND_W'(err);
    end
  end

  // shared multiplier control
  always_comb begin
    mul_ctl  = '{prod_en: 1'b0, acc_op: ACC_HOLD};
    mul_gain = gains.drive_gain;
    mul_opnd = drive_opnd;
    case (state)
      S_DMUL: mul_ctl.prod_en = 1'b1;
      S_DSUM: mul_ctl.acc_op = ACC_LOAD;
      S_HPM: begin
        mul_ctl.prod_en = 1'b1;
        mul_gain = gains.heading_gain_p;
        mul_opnd = OPND_W'(err);
      end
      S_HIM: begin
        mul_ctl  = '{prod_en: 1'b1, acc_op: ACC_LOAD};
        mul_gain = gains.heading_gain_i;
        mul_opnd = heading_integral;
      end
      S_HDM: begin
        mul_ctl  = '{prod_en: 1'b1, acc_op: ACC_ADD};
        mul_gain = gains.heading_gain_d;
        mul_opnd = OPND_W'(dh);
      end
      S_HSUM: mul_ctl.acc_op = ACC_ADD;
      S_RPM: begin
        mul_ctl.prod_en = 1'b1;
        mul_gain = gains.rate_gain_p;
        mul_opnd = OPND_W'(rerr);
      end
      S_RIM: begin
        mul_ctl  = '{prod_en: 1'b1, acc_op: ACC_LOAD};
        mul_gain = gains.rate_gain_i;
        mul_opnd = rate_integral;
      end
      S_RDM: begin
        mul_ctl  = '{prod_en: 1'b1, acc_op: ACC_ADD};
        mul_gain = gains.rate_gain_d;
        mul_opnd = OPND_W'(dr);
      end
      S_RSUM: mul_ctl.acc_op = ACC_ADD;
      default: ;
    endcase
  end

  // final saturation and stop band
  assign fin_drv    = sat(acc, (kind == MODE_DRIVE) ? DRV_LIM : ROUT_LIM);
  assign drv16      = fin_drv[DATA_W-1:0];
  assign band       = in_band(err);
  assign mode_after = ((kind == MODE_DRIVE || kind == MODE_ROTATE) && band) ? MODE_STOP : mode;

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      mode             <= MODE_STOP;
      kind             <= MODE_STOP;
      goal             <= '0;
      heading_integral <= '0;
      rate_integral    <= '0;
      last_heading     <= '0;
      last_rate        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (cmd.func)
              FUNC_DRIVE: begin
                goal  <= cmd.target;
                mode  <= MODE_DRIVE;
                kind  <= MODE_STOP;
                state <= S_FIN;
              end
              FUNC_ROTATE: begin
                goal  <= cmd.target;
                mode  <= MODE_ROTATE;
                kind  <= MODE_STOP;
                state <= S_FIN;
              end
              FUNC_STOP: begin
                mode  <= MODE_STOP;
                kind  <= MODE_STOP;
                state <= S_FIN;
              end
              default: begin
                case (mode)
                  MODE_DRIVE: begin
                    kind  <= MODE_DRIVE;
                    state <= S_DERR;
                  end
                  MODE_ROTATE: begin
                    kind  <= MODE_ROTATE;
                    state <= S_HERR;
                  end
                  default: begin
                    kind  <= MODE_STOP;
                    state <= S_FIN;
                  end
                endcase
              end
            endcase
          end
        end
        S_DERR: state <= S_DMUL;
        S_DMUL: state <= S_DSUM;
        S_DSUM: state <= S_FIN;
        S_HERR: begin
          last_heading <= head;
          state        <= S_HPM;
        end
        S_HPM: begin
          heading_integral <= SUM_W'(sat(ACC_W'(heading_integral) + ACC_W'(err), HSUM_LIM));
          state <= S_HIM;
        end
        S_HIM:  state <= S_HDM;
        S_HDM:  state <= S_HSUM;
        S_HSUM: state <= S_SP;
        S_SP:   state <= S_RERR;
        S_RERR: begin
          last_rate <= rate;
          state     <= S_RPM;
        end
        S_RPM: begin
          rate_integral <= SUM_W'(sat(ACC_W'(rate_integral) + ACC_W'(rerr), RSUM_LIM));
          state <= S_RIM;
        end
        S_RIM:  state <= S_RDM;
        S_RDM:  state <= S_RSUM;
        S_RSUM: state <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            mode  <= mode_after;
            state <= S_IDLE;
            if (kind == MODE_ROTATE && band) begin
              heading_integral <= '0;
              rate_integral    <= '0;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item fields and intermediate values
  always_ff @(posedge clk) begin
    if (accept) begin
      odo  <= cmd.odometer;
      obst <= cmd.obstacle_distance;
      head <= cmd.heading;
      rate <= cmd.turn_rate;
    end
    case (state)
      S_DERR: begin
        err  <= ERR_W'(goal) - ERR_W'(odo);
        room <= DATA_W'({1'b0, obst}) - DATA_W'({1'b0, gains.clearance});
      end
      S_HERR: begin
        err <= ERR_W'(goal) - ERR_W'(head);
        dh  <= ERR_W'(last_heading) - ERR_W'(head);
      end
      S_SP: sp <= DATA_W'(sat(acc, SP_LIM));
      S_RERR: begin
        rerr <= ERR_W'(sp) - ERR_W'(rate);
        dr   <= ERR_W'(last_rate) - ERR_W'(rate);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (motor.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_mode <= mode_after;
      out_done <= (kind == MODE_DRIVE || kind == MODE_ROTATE) && band;
      if (kind == MODE_DRIVE && !band) begin
        out_left  <= drv16;
        out_right <= drv16;
      end else if (kind == MODE_ROTATE && !band) begin
        out_left  <= drv16;
        out_right <= -drv16;
      end else begin
        out_left  <= '0;
        out_right <= '0;
      end
    end
  end

  assign motor.valid       = out_valid;
  assign motor.left_drive  = out_left;
  assign motor.right_drive = out_right;
  assign motor.mode_now    = out_mode;
  assign motor.finished    = out_done;

endmodule

// ----- test/cascaded_pid_steering_unit_test.sv -----
// testbench for the cascaded pid steering unit: item stimulus, motor checks, register setup
// depends on csteer_pkg, csteer_cmd_if, csteer_motor_if and cascaded_pid_steering_unit
`timescale 1ns / 100ps

import csteer_pkg::*;

typedef struct {
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] target;
  logic signed [DATA_W-1:0] odometer;
  logic [CLR_W-1:0]         obstacle_distance;
  logic signed [DATA_W-1:0] heading;
  logic signed [DATA_W-1:0] turn_rate;
} cmd_item_t;

typedef struct {
  logic signed [DATA_W-1:0] left_drive;
  logic signed [DATA_W-1:0] right_drive;
  logic [MODE_W-1:0]        mode_now;
  logic                     finished;
} motor_item_t;

// mirrors the controller state and holds the motor commands still owed by the block
class steer_tracker;
  localparam longint NEAR_BAND = 2;

  logic [GAIN_W-1:0] drive_gain, heading_gain_p, heading_gain_i, heading_gain_d;
  logic [GAIN_W-1:0] rate_gain_p, rate_gain_i, rate_gain_d;
  logic [CLR_W-1:0]  clearance;
  logic [MODE_W-1:0] mode;
  longint            goal, heading_sum, rate_sum, prev_heading, prev_rate;
  motor_item_t       motor_cmds_due[$];
  int                mismatches, checked, finishes, drive_ticks, rotate_ticks;

  function new();
    drive_gain = 256;
    clearance = 20;
    heading_gain_p = 256;
    heading_gain_i = 0;
    heading_gain_d = 0;
    rate_gain_p = 256;
    rate_gain_i = 0;
    rate_gain_d = 0;
    mode = MODE_STOP;
    goal = 0;
    heading_sum = 0;
    rate_sum = 0;
    prev_heading = 0;
    prev_rate = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [GAIN_W-1:0] val);
    case (idx)
      REG_DRIVE_GAIN:     drive_gain = val;
      REG_CLEARANCE:      clearance = val[CLR_W-1:0];
      REG_HEADING_GAIN_P: heading_gain_p = val;
      REG_HEADING_GAIN_I: heading_gain_i = val;
      REG_HEADING_GAIN_D: heading_gain_d = val;
      REG_RATE_GAIN_P:    rate_gain_p = val;
      REG_RATE_GAIN_I:    rate_gain_i = val;
      REG_RATE_GAIN_D:    rate_gain_d = val;
      default: ;
    endcase
  endfunction

  // q8.8 gain times value, floored
  function longint scaled(logic [GAIN_W-1:0] gain, longint v);
    return (longint'(gain) * v) >>> FRAC_W;
  endfunction

  function longint clip(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function int pending();
    return motor_cmds_due.size();
  endfunction

  // work out the motor command owed for an accepted item
  function void take_command(cmd_item_t it);
    longint err, room, drv, sp, rerr, head, rate;
    motor_item_t r;
    r.left_drive = 0;
    r.right_drive = 0;
    r.finished = 0;
    head = longint'(it.heading);
    rate = longint'(it.turn_rate);
    case (it.func)
      FUNC_DRIVE: begin
        goal = longint'(it.target);
        mode = MODE_DRIVE;
      end
      FUNC_ROTATE: begin
        goal = longint'(it.target);
        mode = MODE_ROTATE;
      end
      FUNC_STOP: mode = MODE_STOP;
      default: begin
        if (mode == MODE_DRIVE) begin
          drive_ticks++;
          err = goal - longint'(it.odometer);
          room = longint'(it.obstacle_distance) - longint'(clearance);
          // obstacle closer than the goal limits the drive
          if (err > room) drv = (room > 0) ? scaled(drive_gain, room) : 0;
          else drv = scaled(drive_gain, err);
          drv = clip(drv, DEF_DRIVE_OUT_MAX);
          if (err < NEAR_BAND && err > -NEAR_BAND) begin
            mode = MODE_STOP;
            r.finished = 1;
          end else begin
            r.left_drive = drv[DATA_W-1:0];
            r.right_drive = drv[DATA_W-1:0];
          end
        end else if (mode == MODE_ROTATE) begin
          rotate_ticks++;
          err = goal - head;
          // outer loop: heading to rate setpoint
          sp = scaled(heading_gain_p, err);
          heading_sum = clip(heading_sum + err, DEF_HEADING_SUM_LIMIT);
          sp += scaled(heading_gain_i, heading_sum);
          sp += scaled(heading_gain_d, prev_heading - head);
          prev_heading = head;
          sp = clip(sp, DEF_RATE_SETPOINT_MAX);
          // inner loop: rate to wheel drive
          rerr = sp - rate;
          drv = scaled(rate_gain_p, rerr);
          rate_sum = clip(rate_sum + rerr, DEF_RATE_SUM_LIMIT);
          drv += scaled(rate_gain_i, rate_sum);
          drv += scaled(rate_gain_d, prev_rate - rate);
          prev_rate = rate;
          drv = clip(drv, DEF_RATE_OUT_MAX);
          if (err < NEAR_BAND && err > -NEAR_BAND) begin
            mode = MODE_STOP;
            heading_sum = 0;
            rate_sum = 0;
            r.finished = 1;
          end else begin
            r.left_drive = drv[DATA_W-1:0];
            r.right_drive = -drv[DATA_W-1:0];
          end
        end
      end
    endcase
    r.mode_now = mode;
    motor_cmds_due.push_back(r);
  endfunction

  task flag(string what);
    mismatches++;
    if (mismatches <= 40) $display("mismatch: %s", what);
  endtask

  // compare a motor item from the block with the oldest one owed
  task match_motor(motor_item_t got);
    motor_item_t exp;
    if (motor_cmds_due.size() == 0) begin
      flag($sformatf("motor item with nothing owed (left %0d right %0d)",
                     got.left_drive, got.right_drive));
      return;
    end
    exp = motor_cmds_due.pop_front();
    checked++;
    if (exp.finished) finishes++;
    if (got.left_drive !== exp.left_drive || got.right_drive !== exp.right_drive ||
        got.mode_now !== exp.mode_now || got.finished !== exp.finished)
      flag($sformatf("item %0d: got l=%0d r=%0d mode=%0d fin=%0d, want l=%0d r=%0d mode=%0d fin=%0d",
                     checked, got.left_drive, got.right_drive, got.mode_now, got.finished,
                     exp.left_drive, exp.right_drive, exp.mode_now, exp.finished));
  endtask
endclass

module cascaded_pid_steering_unit_test;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;

  typedef enum {SET_TYPICAL, SET_MAX, SET_ZERO, SET_RANDOM} setting_e;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAIN_W-1:0]    cfg_data;

  csteer_cmd_if   cmd();
  csteer_motor_if motor();

  cascaded_pid_steering_unit dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .motor(motor),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  steer_tracker tracker;
  int           items_sent;
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_req;
  bit           hold_done;

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // run ends if nothing moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cmd.valid && cmd.ready) || (motor.valid && motor.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
        $display("cascaded_pid_steering_unit_test: done, errors");
        $finish;
      end
    end
  end

  // motor side: random stalls, one long hold, checks at the rising edge
  initial begin : motor_sink
    int          hold_left;
    int          stall_left;
    motor_item_t got;
    hold_left = 0;
    stall_left = 0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        motor.ready = 0;
      end else if (stall_left > 0) begin
        stall_left--;
        motor.ready = 0;
      end else if (recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct) begin
        stall_left = $urandom_range(0, 6);
        motor.ready = 0;
      end else begin
        motor.ready = 1;
      end
      @(posedge clk);
      if (motor.valid && motor.ready) begin
        got.left_drive = motor.left_drive;
        got.right_drive = motor.right_drive;
        got.mode_now = motor.mode_now;
        got.finished = motor.finished;
        tracker.match_motor(got);
      end
    end
  end

  function automatic logic signed [DATA_W-1:0] sat16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[DATA_W-1:0];
  endfunction

  function automatic cmd_item_t mk(logic [FUNC_W-1:0] f, int tgt, int odo, int obst,
                                   int head, int rate);
    cmd_item_t it;
    it.func = f;
    it.target = tgt[DATA_W-1:0];
    it.odometer = odo[DATA_W-1:0];
    it.obstacle_distance = obst[CLR_W-1:0];
    it.heading = head[DATA_W-1:0];
    it.turn_rate = rate[DATA_W-1:0];
    return it;
  endfunction

  function automatic cmd_item_t rand_item();
    return mk(FUNC_W'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
              $urandom);
  endfunction

  function automatic int pick_goal();
    if ($urandom_range(0, 3) == 0) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 4000)) - 2000;
  endfunction

  function automatic int pick_offset();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 600)) - 300;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // obstacle distance: often around the clearance, sometimes anywhere, sometimes the maximum
  function automatic int pick_dist();
    int upper;
    upper = int'(tracker.clearance) + 300;
    if (upper > 32767) upper = 32767;
    case ($urandom_range(0, 2))
      0: return $urandom_range(0, 32767);
      1: return $urandom_range(0, upper);
      default: return 32767;
    endcase
  endfunction

  function automatic int pick_rate();
    if ($urandom_range(0, 1) == 0) return int'($urandom_range(0, 1200)) - 600;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic logic [GAIN_W-1:0] pick_gain(setting_e s);
    case (s)
      SET_TYPICAL: return GAIN_W'($urandom_range(64, 768));
      SET_MAX:     return 16'hffff;
      SET_ZERO:    return 16'h0000;
      default: begin
        case ($urandom_range(0, 3))
          0: return 16'h0000;
          1: return 16'hffff;
          2: return GAIN_W'($urandom_range(0, 1024));
          default: return GAIN_W'($urandom_range(0, 65535));
        endcase
      end
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] pick_clearance(setting_e s);
    case (s)
      SET_TYPICAL: return GAIN_W'($urandom_range(0, 200));
      SET_MAX:     return 16'h7fff;
      SET_ZERO:    return 16'h0000;
      default:     return GAIN_W'($urandom_range(0, 1) ? $urandom_range(0, 500)
                                                       : $urandom_range(0, 32767));
    endcase
  endfunction

  // offer one item, with an optional idle burst first, and wait for it to be taken
  task automatic send(input cmd_item_t it);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      gap = $urandom_range(1, 7);
      @(negedge clk);
      cmd.valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd.valid = 1;
    cmd.func = it.func;
    cmd.target = it.target;
    cmd.odometer = it.odometer;
    cmd.obstacle_distance = it.obstacle_distance;
    cmd.heading = it.heading;
    cmd.turn_rate = it.turn_rate;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    tracker.take_command(it);
    items_sent++;
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] val);
    @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
    tracker.set_reg(idx, val);
  endtask

  // drop valid and wait until every owed motor item has come back
  task automatic settle();
    @(negedge clk);
    cmd.valid = 0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input setting_e s);
    cfg_write(REG_DRIVE_GAIN, pick_gain(s));
    cfg_write(REG_CLEARANCE, pick_clearance(s));
    cfg_write(REG_HEADING_GAIN_P, pick_gain(s));
    cfg_write(REG_HEADING_GAIN_I, pick_gain(s));
    cfg_write(REG_HEADING_GAIN_D, pick_gain(s));
    cfg_write(REG_RATE_GAIN_P, pick_gain(s));
    cfg_write(REG_RATE_GAIN_I, pick_gain(s));
    cfg_write(REG_RATE_GAIN_D, pick_gain(s));
  endtask

  // start a drive, close in on the goal over several ticks, maybe stop early
  task automatic drive_run();
    cmd_item_t it;
    int        goal_v, delta, n;
    goal_v = pick_goal();
    it = rand_item();
    it.func = FUNC_DRIVE;
    it.target = goal_v[DATA_W-1:0];
    send(it);
    delta = pick_offset();
    n = $urandom_range(2, 12);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1 && $urandom_range(0, 1)) delta = int'($urandom_range(0, 2)) - 1;
      it = rand_item();
      it.func = FUNC_TICK;
      it.odometer = sat16(goal_v - delta);
      it.obstacle_distance = CLR_W'(pick_dist());
      send(it);
      delta = delta / 2 + int'($urandom_range(0, 4)) - 2;
    end
    if ($urandom_range(0, 5) == 0) begin
      it = rand_item();
      it.func = FUNC_STOP;
      send(it);
    end
  endtask

  // start a rotation, ticks with heading converging and random rates
  task automatic rotate_run();
    cmd_item_t it;
    int        goal_v, delta, n;
    goal_v = pick_goal();
    it = rand_item();
    it.func = FUNC_ROTATE;
    it.target = goal_v[DATA_W-1:0];
    send(it);
    delta = pick_offset();
    n = $urandom_range(2, 14);
    for (int k = 0; k < n; k++) begin
      if (k == n - 1 && $urandom_range(0, 1)) delta = int'($urandom_range(0, 2)) - 1;
      it = rand_item();
      it.func = FUNC_TICK;
      it.heading = sat16(goal_v - delta);
      it.turn_rate = DATA_W'(pick_rate());
      send(it);
      delta = delta / 2 + int'($urandom_range(0, 4)) - 2;
    end
    if ($urandom_range(0, 5) == 0) begin
      it = rand_item();
      it.func = FUNC_STOP;
      send(it);
    end
  endtask

  task automatic run_phase(input setting_e s, input int idle_pct, input int n,
                           input bit with_hold);
    int stop_at;
    int pick;
    settle();
    apply_setting(s);
    send_idle_pct = idle_pct;
    recv_idle_pct = idle_pct;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if (with_hold && !hold_done && items_sent >= stop_at - n / 2) begin
        hold_req = 1;
        hold_done = 1;
      end
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        drive_run();
      end else if (pick < 8) begin
        rotate_run();
      end else begin
        repeat ($urandom_range(1, 3)) send(rand_item());
      end
    end
  endtask

  // main sequence
  initial begin
    rst = 1;
    cfg_we = 0;
    cfg_index = REG_DRIVE_GAIN;
    cfg_data = 0;
    cmd.valid = 0;
    cmd.func = FUNC_TICK;
    cmd.target = 0;
    cmd.odometer = 0;
    cmd.obstacle_distance = 0;
    cmd.heading = 0;
    cmd.turn_rate = 0;
    motor.ready = 0;
    items_sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 0;
    hold_done = 0;
    tracker = new();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed items at reset settings
    send(mk(FUNC_TICK, 32767, -32768, 32767, -32768, 32767));  // tick while stopped
    send(mk(FUNC_STOP, -1, -1, 32767, -1, -1));                 // stop while stopped
    send(mk(FUNC_DRIVE, 100, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 0, 32767, 0, 0));                     // plain proportional drive
    send(mk(FUNC_TICK, 0, 0, 50, 0, 0));                        // obstacle limits drive
    send(mk(FUNC_TICK, 0, 0, 20, 0, 0));                        // no room left
    send(mk(FUNC_TICK, 0, 0, 0, 0, 0));                         // obstacle inside clearance
    send(mk(FUNC_TICK, 0, 99, 32767, 0, 0));                    // goal reached
    send(mk(FUNC_TICK, 0, 0, 32767, 0, 0));                     // tick after finish
    send(mk(FUNC_DRIVE, 32767, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, -32768, 32767, 0, 0));                // largest forward error
    send(mk(FUNC_DRIVE, -32768, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 32767, 0, 0, 0));                     // largest reverse error
    send(mk(FUNC_TICK, 0, -32767, 0, 0, 0));                    // within band from below
    send(mk(FUNC_ROTATE, 1000, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 0, 0, -32768, 32767));                // extreme heading and rate
    send(mk(FUNC_TICK, 0, 0, 0, 32767, -32768));
    send(mk(FUNC_STOP, 0, 0, 0, 0, 0));                         // stop during rotation
    send(mk(FUNC_ROTATE, -500, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 0, 0, -499, 100));                    // heading reached
    send(mk(FUNC_ROTATE, 0, 0, 0, 0, 0));
    send(mk(FUNC_TICK, 0, 0, 0, 2, 0));                         // just outside band
    send(mk(FUNC_DRIVE, 5, 0, 0, 0, 0));                        // new start while rotating
    send(mk(FUNC_TICK, 0, 3, 0, 0, 0));                         // edge of band, no room
    send(mk(FUNC_TICK, 0, 4, 0, 0, 0));

    // random phases over several register settings
    run_phase(SET_TYPICAL, 30, 125, 1);
    run_phase(SET_MAX, 25, 125, 0);
    run_phase(SET_ZERO, 25, 125, 0);
    run_phase(SET_RANDOM, 0, 125, 0);
    run_phase(SET_RANDOM, 35, 125, 0);
    run_phase(SET_TYPICAL, 50, 125, 0);
    run_phase(SET_RANDOM, 0, 125, 0);

    // drain
    settle();
    repeat (40) @(posedge clk);
    $display("covered %0d items: %0d drive ticks, %0d rotate ticks, %0d targets reached",
             items_sent, tracker.drive_ticks, tracker.rotate_ticks, tracker.finishes);
    $display("seven register settings incl. all-max and all-zero, one long motor hold");
    if (tracker.mismatches == 0) begin
      $display("cascaded_pid_steering_unit_test: done, clean");
    end else begin
      $display("cascaded_pid_steering_unit_test: done, errors");
    end
    $finish;
  end
endmodule
